FILE: hdl/i2c_master_byte_engine_defines.svh
// Assertion macros shared by the I2C master byte engine modules.
// Depends on nothing; a module that asserts must have clk and rst_n in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define I2CM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/i2cm_pkg.sv
// Shared types and constants of the I2C master byte engine.
// Used by the front stage, the request queue and the bus sequencer.
package i2cm_pkg;

    // Reset value of the phase length register.
    localparam logic [7:0] PHASE_RESET = 8'd30;

    // Request depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Raw operation codes on the input stream.
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    // Status codes reported with every result.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NACK    = 2'd1;
    localparam logic [1:0] STAT_BUSY    = 2'd2;
    localparam logic [1:0] STAT_BUS_ERR = 2'd3;

    // Command class decided by the front stage.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ_ACK,
        CMD_READ_NACK
    } cmd_t;

    // Sequencer steps; each non-idle step holds the lines for one phase.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START_A,
        ST_START_B,
        ST_START_C,
        ST_STOP_A,
        ST_STOP_B,
        ST_STOP_C,
        ST_STOP_D,
        ST_WR_LOW,
        ST_WR_DATA,
        ST_WR_HIGH,
        ST_AK_LOW,
        ST_AK_REL,
        ST_AK_HIGH,
        ST_AK_END,
        ST_RD_LOW,
        ST_RD_HIGH,
        ST_MA_LOW,
        ST_MA_DATA,
        ST_MA_HIGH,
        ST_MA_END
    } step_t;

    // One classified tick request as it travels through the queue.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] write_data;
        logic       sda_level;
    } tick_req_t;

    // One result item, packed lowest field last so that bit 0 is scl_release.
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic       done_res;
        logic       ready_res;
        logic       sda_release;
        logic       scl_release;
    } result_t;

    // Maps a raw operation code onto a command class; unknown codes map to CMD_NONE.
    function automatic cmd_t classify_op(input logic [2:0] op);
        cmd_t cmd;
        case (op)
            OP_START:     cmd = CMD_START;
            OP_STOP:      cmd = CMD_STOP;
            OP_WRITE:     cmd = CMD_WRITE;
            OP_READ_ACK:  cmd = CMD_READ_ACK;
            OP_READ_NACK: cmd = CMD_READ_NACK;
            default:      cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

endpackage

FILE: hdl/i2cm_front.sv
// Front stage: accepts input ticks, classifies the operation and registers the request.
// Depends on i2cm_pkg.
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] write_data, [8] sda_level, [15:9] zero
    input  logic [2:0]  s_axis_tuser,  // [2:0] operation
    output logic        req_valid,
    input  logic        req_ready,
    output tick_req_t   req_data
);

    logic      valid_reg;
    logic      valid_next;
    tick_req_t data_reg;
    tick_req_t data_next;

    // The stage takes a new request when it is empty or its request moves on.
    assign s_axis_tready = !valid_reg || req_ready;

    // Classify the incoming operation.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_axis_tready)
        begin
            valid_next           = s_axis_tvalid;
            data_next.cmd        = classify_op(s_axis_tuser);
            data_next.write_data = s_axis_tdata[7:0];
            data_next.sda_level  = s_axis_tdata[8];
        end
    end

    // Control state is reset; the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign req_valid = valid_reg;
    assign req_data  = data_reg;

endmodule

FILE: hdl/i2cm_queue.sv
// Two-entry request queue that decouples the front stage from the sequencer.
// Depends on i2cm_pkg and the shared assertion macros.
`include "i2c_master_byte_engine_defines.svh"
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  tick_req_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output tick_req_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tick_req_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Request storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never runs past the depth, and pointers agree with it.
    `I2CM_NEVER(a_queue_overfill, count_reg > CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `I2CM_ASSERT(a_queue_ptrs, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg),
                 "empty queue with unequal pointers")
    `I2CM_ASSERT(a_queue_full_ptrs,
                 (count_reg == CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg),
                 "full queue with unequal pointers")

endmodule

FILE: hdl/i2cm_back.sv
// Bus sequencer: unless stalled, runs one tick request per cycle through the start,
// stop, write, read phases and registers the result. Depends on i2cm_pkg and macros.
`include "i2c_master_byte_engine_defines.svh"
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  tick_req_t   req_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata
);

    localparam int RES_W = $bits(result_t);

    logic [7:0] phase_reg;
    step_t      step_reg;
    step_t      step_next;
    logic [7:0] tick_reg;
    logic [7:0] tick_next;
    logic [3:0] bit_reg;
    logic [3:0] bit_next;
    logic [3:0] bit_inc;
    logic [7:0] shift_reg;
    logic [7:0] shift_next;
    logic       scl_reg;
    logic       scl_next;
    logic       sda_reg;
    logic       sda_next;
    logic       pend_nack_reg;
    logic       pend_nack_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic [7:0] rdata_reg;
    logic [7:0] rdata_next;
    logic       done_now;
    logic       ready_now;
    logic       enter;
    logic [7:0] hold;
    logic       pop;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    result_next;

    // A request is taken whenever the output register is free or drains.
    assign req_ready = !out_valid_reg || m_axis_tready;
    assign pop       = req_valid && req_ready;
    assign ready_now = (step_reg == ST_IDLE);
    assign hold      = (phase_reg == '0) ? 8'd1 : phase_reg;
    assign bit_inc   = bit_reg + 4'd1;

    // Next state of the phase machine for one tick.
    always_comb
    begin
        step_next      = step_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        pend_nack_next = pend_nack_reg;
        status_next    = status_reg;
        rdata_next     = rdata_reg;
        done_now       = 1'b0;
        enter          = 1'b0;
        if (pop)
        begin
            if (ready_now)
            begin
                // Idle: decode a new command.
                bit_next = '0;
                case (req_data.cmd)
                    CMD_START: step_next = ST_START_A;
                    CMD_STOP:  step_next = ST_STOP_A;
                    CMD_WRITE:
                    begin
                        shift_next = req_data.write_data;
                        step_next  = ST_WR_LOW;
                    end
                    CMD_READ_ACK, CMD_READ_NACK:
                    begin
                        pend_nack_next = (req_data.cmd == CMD_READ_NACK);
                        shift_next     = '0;
                        sda_next       = 1'b1;
                        step_next      = ST_RD_LOW;
                    end
                    default: step_next = ST_IDLE;
                endcase
                enter = (step_next != ST_IDLE);
            end
            else if (tick_reg > 8'd1)
            begin
                tick_next = tick_reg - 8'd1;
            end
            else
            begin
                // Last tick of a phase: sample the line and move on.
                case (step_reg)
                    ST_START_A:
                    begin
                        if (!req_data.sda_level)
                        begin
                            status_next = STAT_BUSY;
                            done_now    = 1'b1;
                            step_next   = ST_IDLE;
                        end
                        else
                        begin
                            step_next = ST_START_B;
                        end
                    end
                    ST_START_B:
                    begin
                        if (req_data.sda_level)
                        begin
                            status_next = STAT_BUS_ERR;
                            done_now    = 1'b1;
                            step_next   = ST_IDLE;
                        end
                        else
                        begin
                            step_next = ST_START_C;
                        end
                    end
                    ST_STOP_A:  step_next = ST_STOP_B;
                    ST_STOP_B:  step_next = ST_STOP_C;
                    ST_STOP_C:  step_next = ST_STOP_D;
                    ST_WR_LOW:  step_next = ST_WR_DATA;
                    ST_WR_DATA: step_next = ST_WR_HIGH;
                    ST_WR_HIGH:
                    begin
                        bit_next  = bit_inc;
                        step_next = (bit_inc < 4'd8) ? ST_WR_LOW : ST_AK_LOW;
                    end
                    ST_AK_LOW:  step_next = ST_AK_REL;
                    ST_AK_REL:  step_next = ST_AK_HIGH;
                    ST_AK_HIGH:
                    begin
                        status_next = req_data.sda_level ? STAT_NACK : STAT_OK;
                        step_next   = ST_AK_END;
                    end
                    ST_RD_LOW:  step_next = ST_RD_HIGH;
                    ST_RD_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], req_data.sda_level};
                        bit_next   = bit_inc;
                        if (bit_inc < 4'd8)
                        begin
                            step_next = ST_RD_LOW;
                        end
                        else
                        begin
                            rdata_next = {shift_reg[6:0], req_data.sda_level};
                            step_next  = ST_MA_LOW;
                        end
                    end
                    ST_MA_LOW:  step_next = ST_MA_DATA;
                    ST_MA_DATA: step_next = ST_MA_HIGH;
                    ST_MA_HIGH: step_next = ST_MA_END;
                    ST_START_C, ST_STOP_D, ST_AK_END, ST_MA_END:
                    begin
                        status_next = STAT_OK;
                        done_now    = 1'b1;
                        step_next   = ST_IDLE;
                    end
                    default:
                    begin
                        done_now  = 1'b1;
                        step_next = ST_IDLE;
                    end
                endcase
                if (step_next == ST_IDLE)
                begin
                    tick_next = '0;
                end
                else
                begin
                    enter = 1'b1;
                end
            end

            // Entering a phase sets the lines and reloads the phase timer.
            if (enter)
            begin
                tick_next = hold;
                case (step_next)
                    ST_START_A:
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    ST_START_B, ST_START_C, ST_STOP_B: sda_next = 1'b0;
                    ST_STOP_A, ST_WR_LOW, ST_AK_LOW, ST_AK_END, ST_RD_LOW,
                    ST_MA_LOW, ST_MA_END: scl_next = 1'b0;
                    ST_STOP_C, ST_WR_HIGH, ST_AK_HIGH, ST_RD_HIGH,
                    ST_MA_HIGH: scl_next = 1'b1;
                    ST_STOP_D, ST_AK_REL: sda_next = 1'b1;
                    ST_WR_DATA:
                    begin
                        sda_next   = shift_next[7];
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                    ST_MA_DATA: sda_next = pend_nack_next;
                    default: sda_next = sda_next;
                endcase
            end
        end
    end

    // Result of the tick as seen after its state update.
    always_comb
    begin
        result_next.scl_release = scl_next;
        result_next.sda_release = sda_next;
        result_next.ready_res   = ready_now;
        result_next.done_res    = done_now;
        result_next.status      = status_next;
        result_next.read_data   = rdata_next;
    end

    // Sequencer state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_RESET;
            step_reg      <= ST_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            pend_nack_reg <= 1'b0;
            status_reg    <= STAT_OK;
            rdata_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_reg <= cfg_wr_data;
            end
            step_reg      <= step_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            pend_nack_reg <= pend_nack_next;
            status_reg    <= status_next;
            rdata_reg     <= rdata_next;
            if (req_ready)
            begin
                out_valid_reg <= req_valid;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(16 - RES_W)'(0), out_data_reg};

    // A finished command always leaves the sequencer idle.
    `I2CM_ASSERT(a_done_idles, (pop && done_now) |=> (step_reg == ST_IDLE),
                 "done without returning to idle")
    // A running phase always has time left on its timer.
    `I2CM_NEVER(a_tick_live, (step_reg != ST_IDLE) && (tick_reg == '0),
                "active phase with empty timer")
    // The bit counter never passes one byte.
    `I2CM_NEVER(a_bit_range, bit_reg > 4'd8, "bit counter beyond one byte")

endmodule

FILE: hdl/i2c_master_byte_engine.sv
// I2C master byte engine: one input tick in, one result out, one tick per clock
// while the output is not stalled. An accepted tick passes through the front register,
// the queue and the sequencer output register to the output.
// Each bus phase lasts phase_ticks ticks (at least one); the phase timer sets SCL rate.
// Reset is asynchronous, active low: idle, both lines released, phase_ticks 30.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,     // phase_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [7:0] write_data, [8] sda_level, [15:9] zero
    input  logic [2:0]  s_axis_tuser,    // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // [0] scl_release, [1] sda_release, [2] ready_res,
                                         // [3] done_res, [5:4] status, [13:6] read_data
);

    logic      front_valid;
    logic      front_ready;
    tick_req_t front_data;
    logic      back_valid;
    logic      back_ready;
    tick_req_t back_data;

    // Accept and classify incoming ticks.
    i2cm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .req_valid     (front_valid),
        .req_ready     (front_ready),
        .req_data      (front_data)
    );

    // Short queue between classification and bus sequencing.
    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_data)
    );

    // Run the bus phases and register the results.
    i2cm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req_valid     (back_valid),
        .req_ready     (back_ready),
        .req_data      (back_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
